FILE: design/spirl_pkg.sv
`timescale 1ns / 1ps

package spirl_pkg;

  localparam int unsigned SETTLE_TICKS = 1500;
  localparam logic signed [14:0] ACC_START_ANGLE = 15'sd0;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned WIDE_W = 50;
  localparam int unsigned NUM_W = 33;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_KP      = 3'd0,
    REG_SPEED_KI      = 3'd1,
    REG_BAL_KP        = 3'd2,
    REG_I_SPEED_ANGLE = 3'd3,
    REG_ANGLE_MAX     = 3'd4,
    REG_ANGLE_MIN     = 3'd5,
    REG_BAL_ANGLE     = 3'd6,
    REG_ACC_TIME      = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_INT,
    OP_DIV,
    OP_FIN1,
    OP_FIN2,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] measured_speed;
    logic signed [15:0] target_speed;
    logic        [30:0] run_ticks;
  } in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] p_term;
    logic signed [31:0] i_term;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] res;
    if (v[WIDE_W-1:31] == '0 || v[WIDE_W-1:31] == '1) begin
      res = v[31:0];
    end else if (v[WIDE_W-1]) begin
      res = {1'b1, 31'b0};
    end else begin
      res = {1'b0, {31{1'b1}}};
    end
    return res;
  endfunction

endpackage

FILE: design/speed_pi_with_ramped_limits.sv
`timescale 1ns / 1ps
// Speed-loop PI controller with a clamped integrator and ramped drive limits.
// Input channel (in_valid/in_ready/in_data) carries one measurement per
// transfer: measured speed, target speed and elapsed run time in ticks.
// Output channel (out_valid/out_ready/out_data) returns one result per input
// transfer: the clamped drive, the saturated proportional term and the
// integrator value.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, as the block
// itself does not enforce it. A new input is taken only once the previous
// result has reached the output register. The ramped upper angle is formed
// by a 33-step restoring divider, one quotient bit per cycle.
// The result sits in an output register, so the next input transfer is
// taken while it waits; if the receiver stalls, the following item holds in
// its final step until the output register is free.
// Synchronous active-low reset clears the configuration registers, the
// integrator, the control state and the output valid flag.
module speed_pi_with_ramped_limits (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  spirl_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output spirl_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [spirl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spirl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spirl_pkg::*;

  cmd_t cmd;

  spirl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spirl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data)
  );

endmodule

FILE: design/spirl_ctrl.sv
`timescale 1ns / 1ps

module spirl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output spirl_pkg::cmd_t cmd
);
  import spirl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_INT,
    S_DIV,
    S_FIN1,
    S_FIN2,
    S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = OP_NONE;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_INT;
      end
      S_INT: begin
        cmd.op    = OP_INT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN1: begin
        cmd.op    = OP_FIN1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        cmd.op    = OP_FIN2;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/spirl_dp.sv
`timescale 1ns / 1ps

module spirl_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spirl_pkg::cmd_t                      cmd,
  input  logic                                 cfg_we,
  input  logic [spirl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spirl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  spirl_pkg::in_t                       in_data,
  output spirl_pkg::out_t                      out_data
);
  import spirl_pkg::*;

  logic        [15:0] kp_r, ki_r, bkp_r, acc_r;
  logic        [13:0] ilim_r;
  logic signed [14:0] amax_r, amin_r, bal_r;

  logic signed [16:0]      err_r;
  logic        [30:0]      rt_r;
  logic signed [32:0]      ki_prod_r;
  logic        [31:0]      kk_r;
  logic        [29:0]      bound_r;
  logic signed [NUM_W-1:0] num_r;
  logic signed [31:0]      integ_r;
  logic signed [WIDE_W-1:0] p_wide_r;
  logic                    ramp_r, neg_r;
  logic        [NUM_W-1:0] quo_r;
  logic        [15:0]      rem_r;
  logic signed [31:0]      p_r, lo_r, hi_r, sum_r;
  logic signed [15:0]      top_r;
  out_t                    out_r;

  logic signed [16:0]      acc_left, rt_s;
  logic signed [31:0]      ramp_a, ramp_b;
  logic signed [33:0]      isum;
  logic signed [31:0]      isat, bound_s, inext;
  logic        [16:0]      r2;
  logic                    ge;
  logic signed [NUM_W-1:0] q_s;
  logic signed [16:0]      lo_diff, hi_diff;
  logic signed [33:0]      lo_prod, hi_prod;

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      bkp_r  <= '0;
      ilim_r <= '0;
      amax_r <= '0;
      amin_r <= '0;
      bal_r  <= '0;
      acc_r  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SPEED_KP:      kp_r   <= cfg_data;
        REG_SPEED_KI:      ki_r   <= cfg_data;
        REG_BAL_KP:        bkp_r  <= cfg_data;
        REG_I_SPEED_ANGLE: ilim_r <= cfg_data[13:0];
        REG_ANGLE_MAX:     amax_r <= cfg_data[14:0];
        REG_ANGLE_MIN:     amin_r <= cfg_data[14:0];
        REG_BAL_ANGLE:     bal_r  <= cfg_data[14:0];
        REG_ACC_TIME:      acc_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    acc_left = $signed({1'b0, acc_r}) - $signed({1'b0, rt_r[15:0]});
    rt_s     = $signed({1'b0, rt_r[15:0]});
    ramp_a   = acc_left * ACC_START_ANGLE;
    ramp_b   = rt_s * amax_r;

    isum    = 34'(integ_r) + 34'(ki_prod_r);
    isat    = sat32(WIDE_W'(isum));
    bound_s = $signed({2'b00, bound_r});
    if (rt_r < 31'(SETTLE_TICKS)) begin
      inext = '0;
    end else if (isat > bound_s) begin
      inext = bound_s;
    end else if (isat < -bound_s) begin
      inext = -bound_s;
    end else begin
      inext = isat;
    end

    r2 = {rem_r, quo_r[NUM_W-1]};
    ge = (r2 >= {1'b0, acc_r});

    q_s     = neg_r ? -$signed(quo_r) : $signed(quo_r);
    lo_diff = 17'(amin_r) - 17'(bal_r);
    hi_diff = 17'(top_r) - 17'(bal_r);
    lo_prod = $signed({1'b0, bkp_r}) * lo_diff;
    hi_prod = $signed({1'b0, bkp_r}) * hi_diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (cmd.op == OP_INT) begin
      integ_r <= inext;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        err_r <= 17'(in_data.measured_speed) - 17'(in_data.target_speed);
        rt_r  <= in_data.run_ticks;
      end
      OP_MUL: begin
        ki_prod_r <= $signed({1'b0, ki_r}) * err_r;
        kk_r      <= kp_r * bkp_r;
        bound_r   <= bkp_r * ilim_r;
        num_r     <= NUM_W'(ramp_a) + NUM_W'(ramp_b);
      end
      OP_INT: begin
        p_wide_r <= $signed({1'b0, kk_r}) * err_r;
        ramp_r   <= (acc_r != '0) && (rt_r < 31'(acc_r));
        neg_r    <= num_r[NUM_W-1];
        quo_r    <= num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
        rem_r    <= '0;
      end
      OP_DIV: begin
        rem_r <= ge ? 16'(r2 - {1'b0, acc_r}) : r2[15:0];
        quo_r <= {quo_r[NUM_W-2:0], ge};
      end
      OP_FIN1: begin
        p_r   <= sat32(p_wide_r);
        top_r <= ramp_r ? q_s[15:0] : 16'(amax_r);
        lo_r  <= sat32(-WIDE_W'(lo_prod));
      end
      OP_FIN2: begin
        hi_r  <= sat32(-WIDE_W'(hi_prod));
        sum_r <= sat32(WIDE_W'(p_r) + WIDE_W'(integ_r));
      end
      OP_OUT: begin
        if (sum_r > hi_r) begin
          out_r.drive <= hi_r;
        end else if (sum_r < lo_r) begin
          out_r.drive <= lo_r;
        end else begin
          out_r.drive <= sum_r;
        end
        out_r.p_term <= p_r;
        out_r.i_term <= integ_r;
      end
      default: begin
      end
    endcase
  end

endmodule
